### hdl/marked_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// Marked frame receiver assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MARKED_FRAME_RECEIVER_MACROS_SVH
`define MARKED_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MFR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent in one cycle implies the consequent in the next cycle.
`define MFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MFR_ASSERT(label, clk, rst, prop, msg)
`define MFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### hdl/mfr_pkg.sv
// ----------------------------------------------------------------------------
// Marked frame receiver package
// Shared types, register indexes, event codes and helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_MARK       = 3'd0,
    REG_HEAD_MARK_LEN   = 3'd1,
    REG_TAIL_MARK       = 3'd2,
    REG_TAIL_MARK_LEN   = 3'd3,
    REG_MAX_FRAME_LEN   = 3'd4,
    REG_LEN_FIELD_POS   = 3'd5,
    REG_LEN_FIELD_BYTES = 3'd6,
    REG_LEN_ADJUST      = 3'd7
  } mfr_reg_t;

  // Per-byte event codes.
  typedef enum logic [2:0] {
    EV_STORED    = 3'd0,
    EV_HEAD_MISS = 3'd1,
    EV_COMPLETE  = 3'd2,
    EV_TOO_LONG  = 3'd3,
    EV_MISMATCH  = 3'd4
  } mfr_event_t;

  typedef struct packed {
    logic [31:0] head_mark;
    logic [2:0]  head_mark_len;
    logic [31:0] tail_mark;
    logic [2:0]  tail_mark_len;
    logic [15:0] max_frame_len;
    logic [7:0]  len_field_pos;
    logic [2:0]  len_field_bytes;
    logic [31:0] len_adjust;
  } mfr_cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] byte_pos;
    mfr_event_t  event_res;
    logic [15:0] frame_len;
  } mfr_res_t;

  // Byte k of a four-byte mark; bytes past the register read as zero.
  function automatic logic [7:0] mark_byte(input logic [31:0] mark, input logic [2:0] k);
    logic [7:0] b;
    if (k[2]) begin
      b = 8'd0;
    end else begin
      b = mark[{k[1:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  // Effective length field width: 0 and 1 give 1, 2 gives 2, the rest give 4.
  function automatic logic [2:0] field_width(input logic [2:0] code);
    logic [2:0] w;
    if (code <= 3'd1) begin
      w = 3'd1;
    end else if (code == 3'd2) begin
      w = 3'd2;
    end else begin
      w = 3'd4;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

### hdl/mfr_if.sv
// ----------------------------------------------------------------------------
// Marked frame receiver stream interfaces
// Valid/ready channels for received bytes and per-byte results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel.
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Per-byte result channel.
interface mfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [15:0] byte_pos;
  logic [2:0]  event_res;
  logic [15:0] frame_len;

  modport source (output valid, output out_byte, output byte_pos, output event_res,
                  output frame_len, input ready);
  modport sink   (input valid, input out_byte, input byte_pos, input event_res,
                  input frame_len, output ready);
endinterface

`default_nettype wire

### hdl/mfr_step.sv
// ----------------------------------------------------------------------------
// Marked frame receiver byte step
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfr_step #(
  parameter int MARK_BYTES = 4
) (
  input  mfr_pkg::mfr_cfg_t           cfg,
  input  logic [15:0]                 frame_index,
  input  logic [31:0]                 length_capture,
  input  logic [MARK_BYTES-1:0][7:0]  recent_bytes,
  input  logic [7:0]                  rx_byte,
  output logic [15:0]                 frame_index_next,
  output logic [31:0]                 length_capture_next,
  output logic [MARK_BYTES-1:0][7:0]  recent_bytes_next,
  output mfr_pkg::mfr_res_t           res
);
  import mfr_pkg::*;

  localparam logic [3:0] MARK_LIMIT = 4'(MARK_BYTES);

  logic [3:0]  hlen;
  logic [3:0]  tlen;
  logic        head_miss;
  logic [2:0]  width;
  logic [16:0] idx;
  logic [16:0] field_end;
  logic [16:0] field_off;
  logic        in_field;
  logic [31:0] cap_upd;
  logic [31:0] raw_len;
  logic [31:0] len_total;
  logic        len_known;
  logic        tail_ok;
  logic [2:0]  tail_j;
  mfr_event_t  ev;

  // History shift: newest byte in entry 0.
  always_comb begin
    recent_bytes_next[0] = rx_byte;
    for (int e = 1; e < MARK_BYTES; e++) begin
      recent_bytes_next[e] = recent_bytes[e-1];
    end
  end

  // Tail compare: entry e of the history holds tail byte tlen-1-e.
  always_comb begin
    tail_ok = 1'b1;
    tail_j  = 3'd0;
    for (int e = 0; e < MARK_BYTES; e++) begin
      if (4'(e) < tlen) begin
        tail_j = 3'(tlen - 4'(e) - 4'd1);
        if (recent_bytes_next[e] != mark_byte(cfg.tail_mark, tail_j)) begin
          tail_ok = 1'b0;
        end
      end
    end
  end

  // Head match, length capture and frame end decision.
  always_comb begin
    hlen = ({1'b0, cfg.head_mark_len} > MARK_LIMIT) ? MARK_LIMIT : {1'b0, cfg.head_mark_len};
    tlen = ({1'b0, cfg.tail_mark_len} > MARK_LIMIT) ? MARK_LIMIT : {1'b0, cfg.tail_mark_len};

    head_miss = ({12'd0, hlen} > frame_index) &&
                (mark_byte(cfg.head_mark, frame_index[2:0]) != rx_byte);

    width     = field_width(cfg.len_field_bytes);
    idx       = {1'b0, frame_index} + 17'd1;
    field_end = {9'd0, cfg.len_field_pos} + {14'd0, width};
    field_off = {1'b0, frame_index} - {9'd0, cfg.len_field_pos};
    in_field  = (frame_index >= {8'd0, cfg.len_field_pos}) && (field_off < {14'd0, width});

    cap_upd = length_capture;
    if (in_field) begin
      cap_upd[{field_off[1:0], 3'b000} +: 8] = rx_byte;
    end

    case (width)
      3'd1:    raw_len = {24'd0, cap_upd[7:0]};
      3'd2:    raw_len = {16'd0, cap_upd[15:0]};
      default: raw_len = cap_upd;
    endcase
    len_total = raw_len + cfg.len_adjust;
    len_known = (frame_index >= {12'd0, hlen}) && (idx >= field_end);

    ev                  = EV_STORED;
    frame_index_next    = idx[15:0];
    length_capture_next = cap_upd;
    if (head_miss) begin
      ev                  = EV_HEAD_MISS;
      frame_index_next    = 16'd0;
      length_capture_next = length_capture;
    end else if (len_known) begin
      if (len_total > {16'd0, cfg.max_frame_len}) begin
        ev               = EV_TOO_LONG;
        frame_index_next = 16'd0;
      end else if (({15'd0, idx} == len_total) && tail_ok) begin
        ev               = EV_COMPLETE;
        frame_index_next = 16'd0;
      end else if ({15'd0, idx} >= len_total) begin
        ev               = EV_MISMATCH;
        frame_index_next = 16'd0;
      end
    end

    res.out_byte  = rx_byte;
    res.byte_pos  = frame_index;
    res.event_res = ev;
    res.frame_len = (ev == EV_COMPLETE) ? len_total[15:0] : 16'd0;
  end

endmodule

`default_nettype wire

### hdl/marked_frame_receiver.sv
// ----------------------------------------------------------------------------
// Marked frame receiver
// Byte-serial deframer: head mark, little-endian length field, tail mark.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received byte per beat; res carries one result beat per
//   byte with the byte, its frame position, an event code and, on a
//   completed frame, the total frame length. Registers are written through
//   cfg_wr_en / cfg_index / cfg_wdata while the block is idle, a rule for
//   the user that the block does not enforce. Throughput: one byte per cycle
//   while the skid register is empty; the per-byte state update (head
//   compare, length add and compare, tail compare) is combinational and
//   each result beat is registered. When res stalls, one more byte is taken
//   into a skid register, after which rx.ready drops until the result
//   register drains. Reset clears the frame position, length capture, byte
//   history and both result valid flags, and loads the register defaults
//   (maximum frame length 65535, length field width 1, all others 0).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "marked_frame_receiver_macros.svh"

module marked_frame_receiver #(
  parameter int MARK_BYTES = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  mfr_in_if.sink                        rx,
  mfr_out_if.source                     res,
  input  logic                          cfg_wr_en,
  input  logic [mfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mfr_pkg::*;

  mfr_cfg_t                  cfg;
  logic [15:0]               frame_index;
  logic [31:0]               length_capture;
  logic [MARK_BYTES-1:0][7:0] recent_bytes;

  logic [15:0]               frame_index_next;
  logic [31:0]               length_capture_next;
  logic [MARK_BYTES-1:0][7:0] recent_bytes_next;
  mfr_res_t                  step_res;

  logic                      out_vld;
  mfr_res_t                  out_q;
  logic                      skid_vld;
  mfr_res_t                  skid_q;

  logic                      accept;
  logic                      pop;

  assign rx.ready = !skid_vld;
  assign accept   = rx.valid && !skid_vld;
  assign pop      = out_vld && res.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_mark       <= 32'd0;
      cfg.head_mark_len   <= 3'd0;
      cfg.tail_mark       <= 32'd0;
      cfg.tail_mark_len   <= 3'd0;
      cfg.max_frame_len   <= 16'hFFFF;
      cfg.len_field_pos   <= 8'd0;
      cfg.len_field_bytes <= 3'd1;
      cfg.len_adjust      <= 32'd0;
    end else if (cfg_wr_en) begin
      case (mfr_reg_t'(cfg_index))
        REG_HEAD_MARK:       cfg.head_mark       <= cfg_wdata;
        REG_HEAD_MARK_LEN:   cfg.head_mark_len   <= cfg_wdata[2:0];
        REG_TAIL_MARK:       cfg.tail_mark       <= cfg_wdata;
        REG_TAIL_MARK_LEN:   cfg.tail_mark_len   <= cfg_wdata[2:0];
        REG_MAX_FRAME_LEN:   cfg.max_frame_len   <= cfg_wdata[15:0];
        REG_LEN_FIELD_POS:   cfg.len_field_pos   <= cfg_wdata[7:0];
        REG_LEN_FIELD_BYTES: cfg.len_field_bytes <= cfg_wdata[2:0];
        REG_LEN_ADJUST:      cfg.len_adjust      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-byte step logic.
  mfr_step #(
    .MARK_BYTES (MARK_BYTES)
  ) u_step (
    .cfg                 (cfg),
    .frame_index         (frame_index),
    .length_capture      (length_capture),
    .recent_bytes        (recent_bytes),
    .rx_byte             (rx.rx_byte),
    .frame_index_next    (frame_index_next),
    .length_capture_next (length_capture_next),
    .recent_bytes_next   (recent_bytes_next),
    .res                 (step_res)
  );

  // Frame state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index    <= 16'd0;
      length_capture <= 32'd0;
      recent_bytes   <= '0;
    end else if (accept) begin
      frame_index    <= frame_index_next;
      length_capture <= length_capture_next;
      recent_bytes   <= recent_bytes_next;
    end
  end

  // Result register with a one-beat skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (out_vld && !res.ready) begin
      if (accept) begin
        skid_vld <= 1'b1;
        skid_q   <= step_res;
      end
    end else if (skid_vld) begin
      out_vld  <= 1'b1;
      out_q    <= skid_q;
      skid_vld <= 1'b0;
    end else begin
      out_vld <= accept;
      if (accept) begin
        out_q <= step_res;
      end
    end
  end

  assign res.valid     = out_vld;
  assign res.out_byte  = out_q.out_byte;
  assign res.byte_pos  = out_q.byte_pos;
  assign res.event_res = out_q.event_res;
  assign res.frame_len = out_q.frame_len;

  // The skid stage only fills behind a held result.
  `MFR_ASSERT(a_skid_behind_out, clk, rst, !skid_vld || out_vld, "skid full while result empty")
  // A byte taken while the result is held lands in the skid stage.
  `MFR_ASSERT_NEXT(a_stall_to_skid, clk, rst, accept && out_vld && !pop, skid_vld,
    "accepted beat lost during stall")
  // Any frame-ending event returns the position to zero.
  `MFR_ASSERT_NEXT(a_end_resets_pos, clk, rst, accept && (step_res.event_res != EV_STORED),
    frame_index == 16'd0, "frame position not cleared after frame end")
  // A completed frame ends on its last byte; other events report no length.
  `MFR_ASSERT(a_len_matches_pos, clk, rst,
    !out_vld || ((out_q.event_res == EV_COMPLETE) ?
      (out_q.frame_len == out_q.byte_pos + 16'd1) : (out_q.frame_len == 16'd0)),
    "frame length disagrees with byte position")

endmodule

`default_nettype wire

### verif/marked_frame_receiver_test.sv
// ----------------------------------------------------------------------------
// Marked frame receiver testbench
// Streams framed and unframed bytes through the deframer under changing
// register settings and handshake pressure. A cycle-free predictor of the
// deframer state computes each result beat, and the monitor compares the
// beats the block returns against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marked_frame_receiver_test;
  import mfr_pkg::*;

  localparam int MARK_DEPTH  = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 50000;
  localparam int PRINT_LIMIT = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  mfr_in_if  rx_ch ();
  mfr_out_if res_ch ();

  marked_frame_receiver DUT (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Bytes waiting to be offered, and result beats the deframer still owes.
  logic [7:0] rx_stream[$];
  mfr_res_t   results_due[$];

  // Predicted deframer state and the register values it runs under.
  mfr_cfg_t    regs_now;
  logic [15:0] pos_now;
  logic [31:0] len_field_acc;
  logic [7:0]  recent_rx[MARK_DEPTH];

  int   sender_idle_pct = 0;
  int   recv_stall_pct  = 0;
  logic hold_req        = 1'b0;
  logic hold_active     = 1'b0;
  logic rx_taken        = 1'b0;
  int   fail_count      = 0;

  // Clock generation.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned mark_span(input logic [2:0] n);
    return (n > MARK_DEPTH) ? MARK_DEPTH : n;
  endfunction

  function automatic int unsigned field_span(input logic [2:0] code);
    return (code <= 3'd1) ? 1 : ((code == 3'd2) ? 2 : 4);
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_LIMIT) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
    fail_count++;
  endtask

  // Advance the deframer state by one byte and return the beat it must give.
  function automatic mfr_res_t deframe_byte(input logic [7:0] b);
    mfr_res_t    r;
    logic [31:0] pos, idx, fw, fp, hl, tl, raw, total;
    logic        tail_ok;
    int          k;
    pos = {16'd0, pos_now};
    fw  = field_span(regs_now.len_field_bytes);
    fp  = {24'd0, regs_now.len_field_pos};
    hl  = mark_span(regs_now.head_mark_len);
    r.out_byte  = b;
    r.byte_pos  = pos_now;
    r.event_res = EV_STORED;
    r.frame_len = '0;
    for (k = MARK_DEPTH - 1; k > 0; k--) begin
      recent_rx[k] = recent_rx[k-1];
    end
    recent_rx[0] = b;
    if (pos < hl && regs_now.head_mark[8*pos +: 8] != b) begin
      r.event_res = EV_HEAD_MISS;
      pos_now = '0;
    end else begin
      idx = pos + 1;
      if (pos >= fp && pos < fp + fw) begin
        len_field_acc[8*(pos-fp) +: 8] = b;
      end
      pos_now = idx[15:0];
      // The length is judged once the head and the whole field are in.
      if (pos >= hl && idx >= fp + fw) begin
        case (fw)
          1:       raw = {24'd0, len_field_acc[7:0]};
          2:       raw = {16'd0, len_field_acc[15:0]};
          default: raw = len_field_acc;
        endcase
        total = raw + regs_now.len_adjust;
        if (total > {16'd0, regs_now.max_frame_len}) begin
          r.event_res = EV_TOO_LONG;
          pos_now = '0;
        end else begin
          // The tail is compared against the byte history as it stands.
          tl = mark_span(regs_now.tail_mark_len);
          tail_ok = 1'b1;
          for (k = 0; k < tl; k++) begin
            if (recent_rx[tl-1-k] != regs_now.tail_mark[8*k +: 8]) begin
              tail_ok = 1'b0;
            end
          end
          if (idx == total && tail_ok) begin
            r.event_res = EV_COMPLETE;
            r.frame_len = total[15:0];
            pos_now = '0;
          end else if (idx >= total) begin
            r.event_res = EV_MISMATCH;
            pos_now = '0;
          end
        end
      end
    end
    return r;
  endfunction

  // Byte sender: changes only at the falling edge.
  always @(negedge clk) begin
    if (!rst && (rx_taken || !rx_ch.valid)) begin
      if (rx_stream.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        rx_ch.rx_byte <= rx_stream.pop_front();
        rx_ch.valid   <= 1'b1;
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus the long hold-off when requested.
  always @(negedge clk) begin
    if (rst || hold_active) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // Predict each accepted byte and check each returned beat.
  always @(posedge clk) begin
    mfr_res_t want;
    rx_taken <= !rst && rx_ch.valid && rx_ch.ready;
    if (!rst && rx_ch.valid && rx_ch.ready) begin
      results_due.push_back(deframe_byte(rx_ch.rx_byte));
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result beat byte %02h with nothing expected",
                                  res_ch.out_byte));
      end else begin
        want = results_due.pop_front();
        if (res_ch.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    res_ch.out_byte, want.out_byte));
        end
        if (res_ch.byte_pos !== want.byte_pos) begin
          report_mismatch($sformatf("byte_pos %0d, expected %0d (byte %02h)",
                                    res_ch.byte_pos, want.byte_pos, want.out_byte));
        end
        if (res_ch.event_res !== want.event_res) begin
          report_mismatch($sformatf("event_res %0d, expected %0d (byte %02h pos %0d)",
                                    res_ch.event_res, want.event_res,
                                    want.out_byte, want.byte_pos));
        end
        if (res_ch.frame_len !== want.frame_len) begin
          report_mismatch($sformatf("frame_len %0d, expected %0d (byte %02h pos %0d)",
                                    res_ch.frame_len, want.frame_len,
                                    want.out_byte, want.byte_pos));
        end
      end
    end
  end

  // Wait until every queued byte is in and every result beat has come back.
  task automatic wait_for_results;
    int guard;
    guard = 0;
    while ((rx_stream.size() != 0 || rx_ch.valid || results_due.size() != 0)
           && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (results_due.size() != 0 || rx_stream.size() != 0) begin
      report_mismatch($sformatf("%0d result beats never arrived", results_due.size()));
      results_due.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input mfr_reg_t idx, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // Write all registers; unused upper data bits carry random junk.
  task automatic apply_settings(input mfr_cfg_t s);
    @(negedge clk);
    write_reg(REG_HEAD_MARK,       s.head_mark);
    write_reg(REG_HEAD_MARK_LEN,   {29'($urandom()), s.head_mark_len});
    write_reg(REG_TAIL_MARK,       s.tail_mark);
    write_reg(REG_TAIL_MARK_LEN,   {29'($urandom()), s.tail_mark_len});
    write_reg(REG_MAX_FRAME_LEN,   {16'($urandom()), s.max_frame_len});
    write_reg(REG_LEN_FIELD_POS,   {24'($urandom()), s.len_field_pos});
    write_reg(REG_LEN_FIELD_BYTES, {29'($urandom()), s.len_field_bytes});
    write_reg(REG_LEN_ADJUST,      s.len_adjust);
    cfg_wr_en <= 1'b0;
    regs_now = s;
  endtask

  // Random settings that still let most frames come through whole.
  function automatic mfr_cfg_t random_settings();
    mfr_cfg_t    s;
    int unsigned hl;
    s.head_mark       = $urandom();
    s.head_mark_len   = 3'($urandom_range(7));
    s.tail_mark       = $urandom();
    s.tail_mark_len   = 3'($urandom_range(7));
    s.len_field_bytes = 3'($urandom_range(7));
    hl = mark_span(s.head_mark_len);
    // Now and then the length field lies inside the head.
    if ($urandom_range(9) == 0) begin
      s.len_field_pos = 8'($urandom_range(hl));
    end else begin
      s.len_field_pos = 8'(hl + $urandom_range(3));
    end
    case ($urandom_range(4))
      0:       s.len_adjust = 32'd0;
      1:       s.len_adjust = $urandom_range(10, 1);
      2:       s.len_adjust = 32'd0 - $urandom_range(10, 1);
      3:       s.len_adjust = (field_span(s.len_field_bytes) == 4) ? $urandom() : 32'd0;
      default: s.len_adjust = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(3))
      0, 1:    s.max_frame_len = 16'hFFFF;
      2:       s.max_frame_len = 16'($urandom_range(40, 8));
      default: s.max_frame_len = 16'($urandom());
    endcase
    return s;
  endfunction

  // Queue one frame built for the current settings, sometimes with a bad byte.
  task automatic queue_frame(output int unsigned count);
    logic [7:0]  frame[$];
    logic [31:0] field;
    int unsigned hl, tl, fw, fp, min_len, total, p, hit;
    hl = mark_span(regs_now.head_mark_len);
    tl = mark_span(regs_now.tail_mark_len);
    fw = field_span(regs_now.len_field_bytes);
    fp = regs_now.len_field_pos;
    min_len = ((hl > fp + fw) ? hl : fp + fw) + tl;
    total = min_len + $urandom_range(20);
    if (total > regs_now.max_frame_len && regs_now.max_frame_len >= min_len
        && $urandom_range(3) != 0) begin
      total = $urandom_range(regs_now.max_frame_len, min_len);
    end
    field = total - regs_now.len_adjust;
    for (p = 0; p < total; p++) begin
      if (p < hl) begin
        frame.push_back(regs_now.head_mark[8*p +: 8]);
      end else if (p >= fp && p < fp + fw) begin
        frame.push_back(field[8*(p-fp) +: 8]);
      end else if (p + tl >= total) begin
        frame.push_back(regs_now.tail_mark[8*(p + tl - total) +: 8]);
      end else begin
        frame.push_back(8'($urandom()));
      end
    end
    if ($urandom_range(7) == 0) begin
      hit = $urandom_range(total - 1);
      frame[hit] = frame[hit] ^ 8'($urandom_range(255, 1));
    end
    foreach (frame[i]) begin
      rx_stream.push_back(frame[i]);
    end
    count = total;
  endtask

  // Run limit.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus and phase control.
  initial begin
    mfr_cfg_t    s;
    int          ph, kind, target;
    int unsigned queued, n;
    logic        paused;
    rst = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'd0;
    res_ch.ready  = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_HEAD_MARK;
    cfg_wdata = 32'd0;
    regs_now = '0;
    regs_now.max_frame_len   = 16'hFFFF;
    regs_now.len_field_bytes = 3'd1;
    pos_now       = '0;
    len_field_acc = '0;
    foreach (recent_rx[i]) begin
      recent_rx[i] = 8'd0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: too long, a complete frame whose tail reaches back before it,
    // length already below the position, too long, and a plain tail mismatch.
    s = '0;
    s.tail_mark       = 32'h0077_0299;
    s.tail_mark_len   = 3'd3;
    s.max_frame_len   = 16'd100;
    s.len_field_bytes = 3'd0;
    apply_settings(s);
    rx_stream = '{8'h99, 8'h02, 8'h77, 8'h00, 8'hFF, 8'h01};
    wait_for_results();

    // Directed: oversized mark lengths, a four-byte length field that
    // starts inside the head, a full frame, then a head miss.
    s.head_mark       = 32'h3CC3_5AA5;
    s.head_mark_len   = 3'd6;
    s.tail_mark       = 32'hFFEE_DD00;
    s.tail_mark_len   = 3'd7;
    s.max_frame_len   = 16'hFFFF;
    s.len_field_pos   = 8'd1;
    s.len_field_bytes = 3'd7;
    s.len_adjust      = 32'd9 - 32'h003C_C35A;
    apply_settings(s);
    rx_stream = '{8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h00, 8'h00, 8'hDD, 8'hEE, 8'hFF,
                  8'hA5, 8'h00, 8'hA5, 8'h5A};
    wait_for_results();

    // Random phases under rotating handshake pressure.
    for (ph = 0; ph < 10; ph++) begin
      wait_for_results();
      kind = (ph == 4) ? 1 : ((ph == 5) ? 2 : 0);
      if (kind == 1) begin
        // Upper extremes: every frame runs past the far length field.
        s.head_mark       = 32'hFFFF_FFFF;
        s.head_mark_len   = 3'd7;
        s.tail_mark       = 32'hFFFF_FFFF;
        s.tail_mark_len   = 3'd7;
        s.max_frame_len   = 16'hFFFF;
        s.len_field_pos   = 8'hFF;
        s.len_field_bytes = 3'd7;
        s.len_adjust      = 32'hFFFF_FFFF;
        target = 250;
      end else if (kind == 2) begin
        s = '0;
        target = 60;
      end else begin
        s = random_settings();
        target = 140;
      end
      apply_settings(s);
      case (ph % 4)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 59; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin sender_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      queued = 0;
      paused = 1'b0;
      while (queued < target) begin
        // Once, the sender stops halfway until everything has come back.
        if (ph == 2 && !paused && queued >= target / 2) begin
          wait_for_results();
          paused = 1'b1;
        end
        if (kind == 2 || $urandom_range(11) == 0) begin
          repeat ($urandom_range(3, 1)) begin
            rx_stream.push_back(8'($urandom()));
            queued++;
          end
        end
        if (kind != 2) begin
          queue_frame(n);
          queued += n;
        end
      end
      if (ph == 8) begin
        hold_req = 1'b1;
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
